// ===== hw/rtl/tsa_pkg.sv =====
// Shared types and codes of the tile slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package tsa_pkg;

	localparam int FIELD_W = 6;
	localparam int ENTRY_W = 2 * FIELD_W;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_DEL     = 2'd1,
		OP_RETREAT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_BADCOORD = 2'd3
	} status_t;

	// Which value the output register takes on a load.
	typedef enum logic [2:0] {
		RES_ALLOC,
		RES_FULL,
		RES_POS,
		RES_REUSE,
		RES_DELETE
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     pop;
		logic     retreat;
		logic     probe_step;
		logic     probe_done;
		logic     load;
		res_sel_t sel;
	} tsa_cmd_t;

	typedef struct packed {
		logic       fifo_empty;
		logic       probe_full;
		logic       probe_last;
		logic       out_free;
		logic [1:0] op;
	} tsa_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tsa_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tsa_ctrl.sv =====
// Sequencing state machine of the tile slot allocator.
`timescale 1ns / 1ps
`default_nettype none
module tsa_ctrl import tsa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire tsa_stat_t stat,
	output tsa_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PROBE,
		S_EMIT,
		S_REUSE,
		S_FULL,
		S_DEL,
		S_RET
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = RES_ALLOC;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_ADD: begin
						if (!stat.fifo_empty) begin
							cmd.pop = 1'b1;
							state_d = S_REUSE;
						end else begin
							state_d = S_PROBE;
						end
					end
					OP_DEL:     state_d = S_DEL;
					OP_RETREAT: begin
						cmd.retreat = 1'b1;
						state_d     = S_RET;
					end
					default:    state_d = S_IDLE;
				endcase
			end
			S_PROBE: begin
				// Walk a copy of the cursor over the slots the add needs.
				if (stat.probe_full) begin
					state_d = S_FULL;
				end else if (stat.probe_last) begin
					cmd.probe_done = 1'b1;
					state_d        = S_EMIT;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.sel = RES_ALLOC;
				if (stat.out_free) begin
					cmd.load = 1'b1;
					if (stat.probe_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_REUSE, S_FULL, S_DEL, S_RET: begin
				unique case (state_q)
					S_REUSE: cmd.sel = RES_REUSE;
					S_FULL:  cmd.sel = RES_FULL;
					S_DEL:   cmd.sel = RES_DELETE;
					default: cmd.sel = RES_POS;
				endcase
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			s_tready <= 1'b1;
		end else begin
			state_q  <= state_d;
			s_tready <= (state_d == S_IDLE);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tsa_datapath.sv =====
// Cursor, free-slot queue, configuration and output register of the allocator.
`timescale 1ns / 1ps
`default_nettype none
module tsa_datapath import tsa_pkg::*; #(
	parameter int COLUMNS    = 64,
	parameter int ROWS       = 64,
	parameter int FREE_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [6:0]   cfg_wdata,
	output logic      [6:0]   atlas_columns,
	input  wire logic [15:0]  s_tdata,
	input  wire tsa_cmd_t     cmd,
	output tsa_stat_t         stat,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [15:0]  m_tdata,
	output logic              m_tlast
);

	localparam int CW   = $clog2(COLUMNS);
	localparam int CNW  = $clog2(COLUMNS + 1);
	localparam int RW   = $clog2(ROWS + 1);
	localparam int AW   = $clog2(FREE_DEPTH);
	localparam int NW   = $clog2(FREE_DEPTH + 1);
	localparam int CMPW = (CNW > 7) ? CNW : 7;
	localparam int RCW  = (RW > FIELD_W) ? RW : FIELD_W;

	logic [CW-1:0]      cur_col_q, prb_col_q;
	logic [RW-1:0]      cur_row_q, prb_row_q;
	logic [1:0]         k_q;
	logic [1:0]         op_q, size_q;
	logic [FIELD_W-1:0] scol_q, srow_q;
	logic [AW-1:0]      head_q, tail_q;
	logic [NW-1:0]      count_q;
	logic [ENTRY_W-1:0] rd_entry;
	logic [CNW-1:0]     cols;
	logic [CMPW-1:0]    cfg_ext;
	logic [CW-1:0]      last_col;
	logic [1:0]         n_minus_1;
	logic               del_bad, fifo_full, push;
	status_t            del_status;
	logic [FIELD_W-1:0] res_col, res_row;
	status_t            res_status;
	logic               res_last;
	logic [CW-1:0]      nxt_cur_col, nxt_prb_col;
	logic [RW-1:0]      nxt_cur_row, nxt_prb_row;

	// Column count saturated to 1..COLUMNS; zero acts as one.
	always_comb begin
		cfg_ext = CMPW'(atlas_columns);
		if (cfg_ext == '0) begin
			cols = CNW'(1);
		end else if (cfg_ext > CMPW'(COLUMNS)) begin
			cols = CNW'(COLUMNS);
		end else begin
			cols = CNW'(cfg_ext);
		end
	end
	assign last_col = CW'(cols - CNW'(1));

	// Raster step: any column at or past the last one wraps to the next row.
	always_comb begin
		if (cur_col_q >= last_col) begin
			nxt_cur_col = '0;
			nxt_cur_row = cur_row_q + RW'(1);
		end else begin
			nxt_cur_col = cur_col_q + CW'(1);
			nxt_cur_row = cur_row_q;
		end
		if (prb_col_q >= last_col) begin
			nxt_prb_col = '0;
			nxt_prb_row = prb_row_q + RW'(1);
		end else begin
			nxt_prb_col = prb_col_q + CW'(1);
			nxt_prb_row = prb_row_q;
		end
	end

	always_comb begin
		case (size_q)
			2'd0:    n_minus_1 = 2'd0;
			2'd3:    n_minus_1 = 2'd3;
			default: n_minus_1 = 2'd1;
		endcase
	end

	assign fifo_full = (count_q == NW'(FREE_DEPTH));
	assign del_bad   = (CMPW'(scol_q) >= CMPW'(cols)) || (RCW'(srow_q) >= RCW'(ROWS));
	assign del_status = del_bad ? ST_BADCOORD : (fifo_full ? ST_OVERFLOW : ST_OK);
	assign push = cmd.load && (cmd.sel == RES_DELETE) && (del_status == ST_OK);

	assign stat.fifo_empty = (count_q == '0);
	assign stat.probe_full = (prb_row_q >= RW'(ROWS));
	assign stat.probe_last = (k_q == n_minus_1);
	assign stat.out_free   = !m_tvalid || m_tready;
	assign stat.op         = op_q;

	always_comb begin
		res_col    = FIELD_W'(cur_col_q);
		res_row    = FIELD_W'(cur_row_q);
		res_status = ST_OK;
		res_last   = 1'b1;
		case (cmd.sel)
			RES_ALLOC: res_last = (k_q == n_minus_1);
			RES_FULL:  res_status = ST_FULL;
			RES_REUSE: begin
				res_col = rd_entry[FIELD_W-1:0];
				res_row = rd_entry[ENTRY_W-1:FIELD_W];
			end
			RES_DELETE: begin
				res_col    = scol_q;
				res_row    = srow_q;
				res_status = del_status;
			end
			default: res_last = 1'b1;
		endcase
	end

	tsa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(FREE_DEPTH)
	) u_free_ram (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata({srow_q, scol_q}),
		.re   (cmd.pop),
		.raddr(head_q),
		.rdata(rd_entry)
	);

	// Captured beat fields and output payload need no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= s_tdata[1:0];
			size_q <= s_tdata[3:2];
			scol_q <= s_tdata[9:4];
			srow_q <= s_tdata[15:10];
		end
		if (cmd.load) begin
			m_tdata <= {2'b00, res_status, res_row, res_col};
			m_tlast <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_columns <= 7'd64;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			prb_col_q     <= '0;
			prb_row_q     <= '0;
			k_q           <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			m_tvalid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				atlas_columns <= cfg_wdata;
			end
			if (cmd.capture) begin
				prb_col_q <= cur_col_q;
				prb_row_q <= cur_row_q;
				k_q       <= '0;
			end
			if (cmd.probe_step) begin
				prb_col_q <= nxt_prb_col;
				prb_row_q <= nxt_prb_row;
				k_q       <= k_q + 2'd1;
			end
			if (cmd.probe_done) begin
				k_q <= '0;
			end
			if (cmd.retreat) begin
				if (cur_col_q == '0) begin
					if (cur_row_q != '0) begin
						cur_row_q <= cur_row_q - RW'(1);
						cur_col_q <= last_col;
					end
				end else begin
					cur_col_q <= cur_col_q - CW'(1);
				end
			end
			if (cmd.load && (cmd.sel == RES_ALLOC)) begin
				cur_col_q <= nxt_cur_col;
				cur_row_q <= nxt_cur_row;
				k_q       <= k_q + 2'd1;
			end
			if (cmd.pop) begin
				head_q  <= (head_q == AW'(FREE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - NW'(1);
			end
			if (push) begin
				tail_q  <= (tail_q == AW'(FREE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
				count_q <= count_q + NW'(1);
			end
			if (cmd.load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tile_slot_allocator.sv =====
// Top level of the tile slot allocator: configuration port and unit wiring.
//
// The allocator handles one command beat at a time. An add that reuses a freed
// slot, a delete and a retreat each pass from decode to a result state, which
// loads the result once the output register is free and then returns to idle;
// an unused opcode returns to idle from decode. An add served from the cursor
// first walks a probe over the slots it needs (1, 2 or 4), one slot per cycle,
// and then emits one slot per cycle while the result side accepts. Freed slots
// sit in a FREE_DEPTH entry RAM whose read is issued while the beat is decoded,
// so a reuse costs no more than a delete. A new command beat is taken while the
// last result still waits in the output register. The only register,
// atlas_columns, lies at byte address 0.
`timescale 1ns / 1ps
`default_nettype none
module tile_slot_allocator import tsa_pkg::*; #(
	parameter int COLUMNS    = 64,
	parameter int ROWS       = 64,
	parameter int FREE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[1:0], tile_size[3:2], slot_col[9:4], slot_row[15:10]
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_col[5:0], out_row[11:6], status[13:12], zero[15:14]
	output logic      [15:0] m_tdata,
	output logic             m_tlast
);

	tsa_cmd_t   cmd;
	tsa_stat_t  stat;
	logic       cfg_sel, cfg_we;
	logic [6:0] atlas_columns;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[2] == 1'b0);
	assign cfg_we  = psel && penable && pwrite && pready && cfg_sel;
	assign prdata  = cfg_sel ? {25'd0, atlas_columns} : 32'd0;

	tsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tsa_datapath #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.FREE_DEPTH(FREE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (pwdata[6:0]),
		.atlas_columns(atlas_columns),
		.s_tdata      (s_tdata),
		.cmd          (cmd),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/tsa_checker.sv =====
// Port-level checks of the tile slot allocator and their binding.
`timescale 1ns / 1ps
`default_nettype none
module tsa_port_checks import tsa_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast
);

	// Nothing is offered on the result side in the cycle after reset is seen.
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result beat offered during reset");

	// A stalled result beat keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// The block works on one command at a time.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while busy");

	// Full, overflow and bad coordinate always stand alone as the final beat.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[13:12] == ST_FULL || m_tdata[13:12] == ST_OVERFLOW
			|| m_tdata[13:12] == ST_BADCOORD) |-> m_tlast)
		else $error("error result not marked last");

endmodule

bind tile_slot_allocator tsa_port_checks u_port_checks (.*);
`default_nettype wire
